[rtl/mms_pkg.sv]
package mms_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 12;
  localparam int DIM_W   = 7;
  localparam int POS_W   = 6;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 12;
  localparam int AB_DEPTH = 4096;
  localparam int C_DEPTH  = 64;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_WRITE_C = 2'd2,
    OP_RUN     = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ROW_COUNT    = 3'd0,
    REG_INNER_COUNT  = 3'd1,
    REG_COL_COUNT    = 3'd2,
    REG_SLICE_LENGTH = 3'd3,
    REG_SLICE_OFFSET = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_BASE,
    ST_CLOAD,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic valid;
  } mac_ctl_t;

endpackage

[rtl/mms_if.sv]
interface mms_in_if import mms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (output valid, operation, element_index, element_value, input ready);
  modport sink (input valid, operation, element_index, element_value, output ready);
endinterface

interface mms_out_if import mms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [POS_W-1:0]        result_position;
  logic                    last_of_run;
  logic                    range_error;

  modport source (output valid, result_value, result_position, last_of_run, range_error,
                  input ready);
  modport sink (input valid, result_value, result_position, last_of_run, range_error,
                output ready);
endinterface

[rtl/matrix_multiply_slice_core.sv]
// Slice of a dense Q16.16 matrix multiply-accumulate. Input words with operation
// write A, write B or write C load one store entry; a write C whose index is not
// below MAX_SLICE is dropped. A run word computes slice_length product elements
// from flat position slice_offset, each the preloaded C entry plus the saturated
// dot product of an A row and a B column, and emits them in order with the last
// one marked. One multiply-accumulate unit does all the work, fed by one A and one
// B memory read per cycle as it accumulates; input is not ready during a run.
// A run whose dimensions are out of range or whose slice passes rows times cols
// gives a single error word and changes nothing. The user must write the registers
// only while idle; the block does not enforce it. Stores are not cleared at reset.
module matrix_multiply_slice_core import mms_pkg::*; #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_SLICE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data,
  mms_in_if.sink              in_ch,
  mms_out_if.source           out_ch
);

  localparam logic [8:0]       MAX_ROWS_W  = 9'(MAX_ROWS);
  localparam logic [8:0]       MAX_INNER_W = 9'(MAX_INNER);
  localparam logic [8:0]       MAX_COLS_W  = 9'(MAX_COLS);
  localparam logic [8:0]       MAX_SLICE_W = 9'(MAX_SLICE);
  localparam logic [IDX_W-1:0] C_LIMIT     = IDX_W'(MAX_SLICE);

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]   rows_r, inner_r, cols_r, len_r;
  logic [IDX_W-1:0]   offset_r;

  logic [IDX_W-1:0]   num_r, quo_r;
  logic [3:0]         div_cnt_r;
  logic [DIM_W-1:0]   col_r;
  logic [IDX_W-1:0]   a_base_r, b_ptr_r;
  logic [DIM_W-1:0]   k_r;
  logic [POS_W-1:0]   p_r;
  logic               rd_v_r;

  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_last_r;
  logic               out_err_r;

  logic [DIM_W:0]     trial;
  logic               trial_ge;
  logic [2*DIM_W-1:0] area;
  logic [IDX_W:0]     slice_end;
  logic               run_err;
  logic               div_done, last_issue, last_elem, out_free, in_acc;

  logic               in_ready, a_we, b_we, c_we, issue, out_load_val, out_load_err;
  logic [POS_W-1:0]   c_waddr;
  logic [VAL_W-1:0]   c_wdata;
  logic [IDX_W-1:0]   a_raddr;
  logic [VAL_W-1:0]   a_rdata, b_rdata, c_rdata;
  mac_ctl_t           mac_ctl;
  logic signed [VAL_W-1:0] acc;
  logic               mac_busy;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign area      = rows_r * cols_r;
  assign slice_end = {1'b0, offset_r} + {{(IDX_W-DIM_W+1){1'b0}}, len_r};
  assign run_err   = (rows_r == '0) || ({2'b0, rows_r} > MAX_ROWS_W) ||
                     (inner_r == '0) || ({2'b0, inner_r} > MAX_INNER_W) ||
                     (cols_r == '0) || ({2'b0, cols_r} > MAX_COLS_W) ||
                     (len_r == '0) || ({2'b0, len_r} > MAX_SLICE_W) ||
                     ({1'b0, slice_end} > {1'b0, area});

  assign trial      = {col_r, num_r[IDX_W-1]};
  assign trial_ge   = trial >= {1'b0, cols_r};
  assign div_done   = div_cnt_r == 4'(IDX_W-1);
  assign last_issue = k_r == (inner_r - 1'b1);
  assign last_elem  = ({1'b0, p_r} + 1'b1) == len_r;
  assign a_raddr    = a_base_r + {{(IDX_W-DIM_W){1'b0}}, k_r};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(1);
      inner_r  <= DIM_W'(1);
      cols_r   <= DIM_W'(1);
      len_r    <= DIM_W'(1);
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    rows_r   <= cfg_data[DIM_W-1:0];
        REG_INNER_COUNT:  inner_r  <= cfg_data[DIM_W-1:0];
        REG_COL_COUNT:    cols_r   <= cfg_data[DIM_W-1:0];
        REG_SLICE_LENGTH: len_r    <= cfg_data[DIM_W-1:0];
        REG_SLICE_OFFSET: offset_r <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_ch.operation == OP_RUN) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = run_err ? ST_ERR : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_BASE;
      ST_BASE:  state_nxt = ST_CLOAD;
      ST_CLOAD: state_nxt = ST_MAC;
      ST_MAC:   if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rd_v_r && !mac_busy) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = last_elem ? ST_IDLE : ST_CLOAD;
      ST_ERR:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    a_we         = 1'b0;
    b_we         = 1'b0;
    c_we         = 1'b0;
    c_waddr      = in_ch.element_index[POS_W-1:0];
    c_wdata      = in_ch.element_value;
    issue        = 1'b0;
    mac_ctl      = '0;
    out_load_val = 1'b0;
    out_load_err = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        a_we     = in_ch.valid && in_ch.operation == OP_WRITE_A;
        b_we     = in_ch.valid && in_ch.operation == OP_WRITE_B;
        c_we     = in_ch.valid && in_ch.operation == OP_WRITE_C &&
                   in_ch.element_index < C_LIMIT;
      end
      ST_MAC: begin
        issue        = 1'b1;
        mac_ctl.load = k_r == '0;
      end
      ST_EMIT: begin
        out_load_val = out_free;
        c_we         = out_free;
        c_waddr      = p_r;
        c_wdata      = acc;
      end
      ST_ERR:  out_load_err = out_free;
      default: ;
    endcase
    mac_ctl.valid = rd_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CHECK: begin
        num_r     <= offset_r;
        quo_r     <= '0;
        col_r     <= '0;
        div_cnt_r <= '0;
        p_r       <= '0;
      end
      ST_DIV: begin
        num_r     <= {num_r[IDX_W-2:0], 1'b0};
        quo_r     <= {quo_r[IDX_W-2:0], trial_ge};
        col_r     <= trial_ge ? DIM_W'(trial - {1'b0, cols_r}) : trial[DIM_W-1:0];
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_BASE:  a_base_r <= IDX_W'(quo_r * inner_r);
      ST_CLOAD: begin
        k_r     <= '0;
        b_ptr_r <= {{(IDX_W-DIM_W){1'b0}}, col_r};
      end
      ST_MAC: begin
        k_r     <= k_r + 1'b1;
        b_ptr_r <= b_ptr_r + {{(IDX_W-DIM_W){1'b0}}, cols_r};
      end
      ST_EMIT: begin
        if (out_free) begin
          p_r <= p_r + 1'b1;
          if (col_r + 1'b1 == cols_r) begin
            col_r    <= '0;
            a_base_r <= a_base_r + {{(IDX_W-DIM_W){1'b0}}, inner_r};
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_val || out_load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load_val) begin
      out_value_r <= acc;
      out_pos_r   <= p_r;
      out_last_r  <= last_elem;
      out_err_r   <= 1'b0;
    end else if (out_load_err) begin
      out_value_r <= '0;
      out_pos_r   <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_value    = out_value_r;
  assign out_ch.result_position = out_pos_r;
  assign out_ch.last_of_run     = out_last_r;
  assign out_ch.range_error     = out_err_r;

  mms_ram #(.WIDTH(VAL_W), .DEPTH(AB_DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_ch.element_index),
    .wdata (in_ch.element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mms_ram #(.WIDTH(VAL_W), .DEPTH(AB_DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_ch.element_index),
    .wdata (in_ch.element_value),
    .raddr (b_ptr_r),
    .rdata (b_rdata)
  );

  mms_ram #(.WIDTH(VAL_W), .DEPTH(C_DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (p_r),
    .rdata (c_rdata)
  );

  mms_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .init_val (c_rdata),
    .a        (a_rdata),
    .b        (b_rdata),
    .acc      (acc),
    .busy     (mac_busy)
  );

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |-> out_ch.last_of_run && out_ch.result_value == '0)
    else $error("error word carries data");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !rd_v_r && !mac_busy)
    else $error("emit before accumulator drained");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BASE || state_r == ST_CLOAD |-> col_r < cols_r)
    else $error("column out of range");

  a_mac_scope: assert property (@(posedge clk) disable iff (!rst_n)
    mac_busy |-> state_r == ST_MAC || state_r == ST_DRAIN)
    else $error("accumulate outside dot product");

endmodule

[rtl/mms_ram.sv]
module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mms_mac.sv]
module mms_mac import mms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] init_val,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic signed [VAL_W-1:0] acc,
  output logic                    busy
);

  logic signed [2*VAL_W-1:0] prod_r;
  logic                      prod_v_r;
  logic signed [VAL_W-1:0]   acc_r;
  logic signed [2*VAL_W-17:0] sh;
  logic signed [VAL_W-1:0]   sh_sat;
  logic signed [VAL_W:0]     sum;
  logic signed [VAL_W-1:0]   sum_sat;

  // floor shift by 16, then clamp to 32 bits
  assign sh = prod_r[2*VAL_W-1:16];
  assign sh_sat = (&sh[2*VAL_W-17:VAL_W-1] || ~|sh[2*VAL_W-17:VAL_W-1]) ? sh[VAL_W-1:0] :
                  (sh[2*VAL_W-17] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});
  assign sum = {acc_r[VAL_W-1], acc_r} + {sh_sat[VAL_W-1], sh_sat};
  assign sum_sat = (sum[VAL_W] == sum[VAL_W-1]) ? sum[VAL_W-1:0] :
                   (sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.valid;
    end
    prod_r <= a * b;
    if (ctl.load) begin
      acc_r <= init_val;
    end else if (prod_v_r) begin
      acc_r <= sum_sat;
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule
